>>> rtl/core/stom_pkg.sv
// Shared constants and types for the seismic trace offset mute block.
package stom_pkg;

    localparam int MAX_POINTS  = 64;
    localparam int MAX_TAPER   = 256;
    localparam int MAX_SAMPLES = 65536;
    localparam int PT_AW       = $clog2(MAX_POINTS);
    localparam int WT_AW       = $clog2(MAX_TAPER);
    localparam int POS_W       = $clog2(MAX_SAMPLES + MAX_TAPER + 1);
    localparam int DIV_W       = 66;
    localparam int REM_W       = 34;

    localparam logic [1:0] MODE_POINT  = 2'd0;
    localparam logic [1:0] MODE_WEIGHT = 2'd1;
    localparam logic [1:0] MODE_HEADER = 2'd2;
    localparam logic [1:0] MODE_SAMPLE = 2'd3;

    localparam logic REG_POINT_COUNT  = 1'b0;
    localparam logic REG_TAPER_LENGTH = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SCAN, ST_RDJ, ST_RDJ1, ST_CALC, ST_MUL, ST_DIV,
        ST_POST, ST_TIME, ST_SMUL, ST_SOUT
    } state_t;

    typedef enum logic [1:0] {
        CLS_PASS, CLS_ZERO, CLS_TAPER
    } cls_t;

endpackage

>>> rtl/core/seismic_trace_offset_mute.sv
// Top mute with a weight-table taper driven by a piecewise-linear offset/time curve.
//
// Items enter on the s_ stream; tuser carries the mode. Point loads and weight
// loads write the two table memories and produce no result. A header item
// scans the point table one entry per cycle, interpolates with a shift-add
// multiplier and a shared restoring divider (run up to twice), and holds
// s_tready low while it works. A sample item goes through a weight memory
// read and a multiply, then its result is loaded into the output register,
// and m_tvalid rises the cycle after. The next item is accepted while a result
// still waits in the output register; if the receiver stalls, the block
// waits with the next sample's result until the register frees up.
// Loads are written as they are accepted. Reset (aresetn low, synchronous)
// clears the control state, sets point_count to 1 and taper_length to 0,
// and disables the mute until the first header with a nonzero interval;
// table contents are undefined until loaded. The user must write
// configuration over the APB port only while idle; the block does not enforce it.
module seismic_trace_offset_mute (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // index, offset, time_us, weight, delay_ms, interval_us, sample (lowest bits first)
    input  logic [151:0] s_tdata,
    // mode
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // sample_out
    output logic [31:0]  m_tdata,
    // zeroed
    output logic [0:0]   m_tuser,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import stom_pkg::*;

    // Input fields.
    logic        [7:0]  in_index;
    logic signed [31:0] in_offset, in_time, in_sample;
    logic        [15:0] in_weight, in_iv;
    logic signed [15:0] in_delay;
    assign in_index  = s_tdata[7:0];
    assign in_offset = s_tdata[39:8];
    assign in_time   = s_tdata[71:40];
    assign in_weight = s_tdata[87:72];
    assign in_delay  = s_tdata[103:88];
    assign in_iv     = s_tdata[119:104];
    assign in_sample = s_tdata[151:120];

    // Configuration.
    logic [6:0] pc_reg;
    logic [8:0] tlen_reg;
    logic       cfg_we;
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;
    assign prdata = (paddr[2] == REG_POINT_COUNT) ? {25'd0, pc_reg} : {23'd0, tlen_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg   <= 7'd1;
            tlen_reg <= 9'd0;
        end else if (cfg_we) begin
            if (paddr[2] == REG_POINT_COUNT) pc_reg <= pwdata[6:0];
            else tlen_reg <= pwdata[8:0];
        end
    end

    logic [PT_AW-1:0] n_last;
    logic [8:0]       tl_eff;
    always_comb begin
        if (pc_reg == 7'd0) n_last = '0;
        else if (pc_reg > 7'(MAX_POINTS)) n_last = PT_AW'(MAX_POINTS - 1);
        else n_last = PT_AW'(pc_reg - 7'd1);
        tl_eff = (tlen_reg > 9'(MAX_TAPER)) ? 9'(MAX_TAPER) : tlen_reg;
    end

    // Table memories.
    logic [63:0] pt_mem [MAX_POINTS];
    logic [15:0] wt_mem [MAX_TAPER];
    logic [63:0] pt_rd_reg;
    logic [15:0] wt_rd_reg;
    logic [PT_AW-1:0] pt_raddr;
    logic [WT_AW-1:0] wt_raddr;
    logic pt_we, wt_we;
    logic [15:0] wt_sat;

    assign wt_sat = (in_weight > 16'd32768) ? 16'd32768 : in_weight;

    always_ff @(posedge aclk) begin
        if (pt_we) pt_mem[in_index[PT_AW-1:0]] <= {in_time, in_offset};
        pt_rd_reg <= pt_mem[pt_raddr];
    end

    always_ff @(posedge aclk) begin
        if (wt_we) wt_mem[in_index[WT_AW-1:0]] <= wt_sat;
        wt_rd_reg <= wt_mem[wt_raddr];
    end

    logic signed [31:0] rd_off, rd_t;
    assign rd_off = pt_rd_reg[31:0];
    assign rd_t   = pt_rd_reg[63:32];

    // Control and datapath registers.
    state_t state_reg, state_next;
    logic [6:0] cnt_reg, cnt_next;
    logic [PT_AW-1:0] j_reg, j_next;
    logic signed [31:0] x_reg, x_next, off0_reg, off0_next, offl_reg, offl_next;
    logic signed [31:0] tlast_reg, tlast_next, offj_reg, offj_next, tj_reg, tj_next;
    logic signed [31:0] offj1_reg, offj1_next, tj1_reg, tj1_next;
    logic signed [26:0] start_reg, start_next;
    logic [15:0] iv_reg, iv_next;
    logic signed [34:0] t_reg, t_next;
    logic neg_reg, neg_next;
    logic [32:0] den_reg, den_next;
    logic [DIV_W-1:0] mcand_reg, mcand_next, acc_reg, acc_next;
    logic [32:0] mplier_reg, mplier_next;
    logic [DIV_W-1:0] num_reg, num_next;
    logic [REM_W-1:0] rem_reg, rem_next, dden_reg, dden_next;
    logic sel_reg, sel_next;
    logic [16:0] mi_reg, mi_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic en_reg, en_next;
    cls_t cls_reg, cls_next;
    logic signed [31:0] smp_reg, smp_next;
    logic signed [48:0] prod_reg, prod_next;
    logic ov_reg, ov_next;
    logic [31:0] od_reg, od_next;
    logic oz_reg, oz_next;

    // Combinational helpers.
    logic signed [32:0] c_den, c_a, c_dt;
    logic [REM_W-1:0] rem_sh;
    logic signed [35:0] d_val;
    logic signed [34:0] q35;
    logic [POS_W-1:0] diff;
    logic signed [49:0] rnd;
    logic in_acc;

    assign in_acc   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign c_den  = 33'(offj1_reg) - 33'(offj_reg);
    assign c_a    = 33'(x_reg) - 33'(offj_reg);
    assign c_dt   = 33'(tj1_reg) - 33'(tj_reg);
    assign rem_sh = {rem_reg[REM_W-2:0], num_reg[DIV_W-1]};
    assign d_val  = 36'(t_reg) - 36'(start_reg);
    assign q35    = $signed({2'b00, num_reg[32:0]});
    assign diff   = pos_reg - POS_W'(mi_reg);
    assign rnd    = 50'(prod_reg) + 50'sd16384;

    always_comb begin
        state_next = state_reg;  cnt_next = cnt_reg;  j_next = j_reg;
        x_next = x_reg;  off0_next = off0_reg;  offl_next = offl_reg;
        tlast_next = tlast_reg;  offj_next = offj_reg;  tj_next = tj_reg;
        offj1_next = offj1_reg;  tj1_next = tj1_reg;  start_next = start_reg;
        iv_next = iv_reg;  t_next = t_reg;  neg_next = neg_reg;  den_next = den_reg;
        mcand_next = mcand_reg;  acc_next = acc_reg;  mplier_next = mplier_reg;
        num_next = num_reg;  rem_next = rem_reg;  dden_next = dden_reg;
        sel_next = sel_reg;  mi_next = mi_reg;  pos_next = pos_reg;  en_next = en_reg;
        cls_next = cls_reg;  smp_next = smp_reg;  prod_next = prod_reg;
        ov_next = ov_reg && !m_tready;  od_next = od_reg;  oz_next = oz_reg;
        pt_raddr = '0;  wt_raddr = '0;  pt_we = 1'b0;  wt_we = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    case (s_tuser)
                        MODE_POINT: pt_we = (in_index < 8'(MAX_POINTS));
                        MODE_WEIGHT: wt_we = 1'b1;
                        MODE_HEADER: begin
                            pos_next = '0;
                            if (in_iv == 16'd0) begin
                                en_next = 1'b0;
                                mi_next = '0;
                            end else begin
                                x_next     = in_offset;
                                start_next = 27'(in_delay) * 27'sd1000;
                                iv_next    = in_iv;
                                j_next     = '0;
                                cnt_next   = '0;
                                state_next = ST_SCAN;
                            end
                        end
                        default: begin
                            smp_next = in_sample;
                            if (en_reg && (pos_reg < POS_W'(mi_reg))) cls_next = CLS_ZERO;
                            else if (en_reg && (diff < POS_W'(tl_eff))) cls_next = CLS_TAPER;
                            else cls_next = CLS_PASS;
                            wt_raddr = diff[WT_AW-1:0];
                            if (pos_reg < POS_W'(MAX_SAMPLES + MAX_TAPER))
                                pos_next = pos_reg + POS_W'(1);
                            state_next = ST_SMUL;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                // Entry cnt_reg is on the read port this cycle.
                if (cnt_reg == 7'd0) off0_next = rd_off;
                if ((cnt_reg != 7'd0) && (cnt_reg < 7'(n_last)) && (rd_off <= x_reg))
                    j_next = cnt_reg[PT_AW-1:0];
                if (cnt_reg == 7'(n_last)) begin
                    offl_next  = rd_off;
                    tlast_next = rd_t;
                    pt_raddr   = j_next;
                    state_next = ST_RDJ;
                end else begin
                    pt_raddr   = PT_AW'(cnt_reg + 7'd1);
                    cnt_next   = cnt_reg + 7'd1;
                end
            end
            ST_RDJ: begin
                offj_next  = rd_off;
                tj_next    = rd_t;
                pt_raddr   = j_reg + PT_AW'(1);
                state_next = ST_RDJ1;
            end
            ST_RDJ1: begin
                offj1_next = rd_off;
                tj1_next   = rd_t;
                state_next = ST_CALC;
            end
            ST_CALC: begin
                state_next = ST_TIME;
                if (x_reg < off0_reg) t_next = 35'(start_reg);
                else if (x_reg > offl_reg || n_last == '0) t_next = 35'(tlast_reg);
                else if (c_den <= 33'sd0) t_next = 35'(tj_reg);
                else begin
                    mcand_next  = DIV_W'((c_a > c_den) ? c_den : c_a);
                    neg_next    = c_dt[32];
                    mplier_next = c_dt[32] ? 33'(-c_dt) : 33'(c_dt);
                    den_next    = c_den;
                    acc_next    = '0;
                    cnt_next    = '0;
                    state_next  = ST_MUL;
                end
            end
            ST_MUL: begin
                if (mplier_reg[0]) acc_next = acc_reg + mcand_reg;
                mcand_next  = {mcand_reg[DIV_W-2:0], 1'b0};
                mplier_next = mplier_reg >> 1;
                cnt_next    = cnt_reg + 7'd1;
                if (cnt_reg == 7'd32) begin
                    // Rounded quotient: add half the divisor first.
                    num_next   = acc_next + DIV_W'(den_reg[32:1]);
                    dden_next  = REM_W'(den_reg);
                    rem_next   = '0;
                    sel_next   = 1'b0;
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (rem_sh >= dden_reg) begin
                    rem_next = rem_sh - dden_reg;
                    num_next = {num_reg[DIV_W-2:0], 1'b1};
                end else begin
                    rem_next = rem_sh;
                    num_next = {num_reg[DIV_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'(DIV_W - 1)) state_next = ST_POST;
            end
            ST_POST: begin
                if (!sel_reg) begin
                    t_next     = neg_reg ? 35'(tj_reg) - q35 : 35'(tj_reg) + q35;
                    state_next = ST_TIME;
                end else begin
                    if ((|num_reg[DIV_W-1:17]) || (num_reg[16:0] > 17'(MAX_SAMPLES)))
                        mi_next = 17'(MAX_SAMPLES);
                    else
                        mi_next = num_reg[16:0];
                    en_next    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_TIME: begin
                if (d_val > 36'sd0) begin
                    num_next   = DIV_W'({d_val, 1'b0}) + DIV_W'(iv_reg);
                    dden_next  = REM_W'({iv_reg, 1'b0});
                    rem_next   = '0;
                    sel_next   = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end else begin
                    mi_next    = '0;
                    en_next    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_SMUL: begin
                prod_next  = 49'(smp_reg) * $signed({1'b0, wt_rd_reg});
                state_next = ST_SOUT;
            end
            ST_SOUT: begin
                if (!ov_reg || m_tready) begin
                    ov_next = 1'b1;
                    oz_next = (cls_reg == CLS_ZERO);
                    case (cls_reg)
                        CLS_ZERO:  od_next = '0;
                        CLS_TAPER: od_next = rnd[46:15];
                        default:   od_next = smp_reg;
                    endcase
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            mi_reg    <= '0;
            pos_reg   <= '0;
            en_reg    <= 1'b0;
            ov_reg    <= 1'b0;
            cnt_reg   <= '0;
            sel_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            mi_reg    <= mi_next;
            pos_reg   <= pos_next;
            en_reg    <= en_next;
            ov_reg    <= ov_next;
            cnt_reg   <= cnt_next;
            sel_reg   <= sel_next;
        end
    end

    always_ff @(posedge aclk) begin
        j_reg <= j_next;  x_reg <= x_next;  off0_reg <= off0_next;  offl_reg <= offl_next;
        tlast_reg <= tlast_next;  offj_reg <= offj_next;  tj_reg <= tj_next;
        offj1_reg <= offj1_next;  tj1_reg <= tj1_next;  start_reg <= start_next;
        iv_reg <= iv_next;  t_reg <= t_next;  neg_reg <= neg_next;  den_reg <= den_next;
        mcand_reg <= mcand_next;  acc_reg <= acc_next;  mplier_reg <= mplier_next;
        num_reg <= num_next;  rem_reg <= rem_next;  dden_reg <= dden_next;
        cls_reg <= cls_next;  smp_reg <= smp_next;  prod_reg <= prod_next;
        od_reg <= od_next;  oz_reg <= oz_next;
    end

    assign m_tvalid   = ov_reg;
    assign m_tdata    = od_reg;
    assign m_tuser[0] = oz_reg;

`ifndef SYNTHESIS
    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (cnt_reg <= 7'(n_last)))
        else $error("point scan ran past the last valid point");
    a_mi_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        mi_reg <= 17'(MAX_SAMPLES))
        else $error("mute index above saturation limit");
    a_zero_iv: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_acc && s_tuser == MODE_HEADER && in_iv == 16'd0) |=>
        (!en_reg && state_reg == ST_IDLE))
        else $error("zero-interval header left mute enabled");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SOUT && ov_reg && !m_tready) |=> (state_reg == ST_SOUT))
        else $error("result overwrote a pending output");
`endif

endmodule
